>>> src/tmil_pkg.sv
// Shared types, constants and command codes of the tile-map image loader.
`default_nettype none

package tmil_pkg;

  // Default largest map side; the top level hands it down as a parameter.
  localparam int MAX_SIDE_DEF = 128;

  // Header layout: magic in bytes 0 to 3, four 16-bit fields up to byte 11,
  // reserved flags up to byte 15, then cells.
  localparam int HDR_MAGIC_END  = 4;
  localparam int HDR_FIELDS_END = 12;
  localparam int HDR_BYTES      = 16;

  // Reset value of the default tile size register.
  localparam logic [15:0] DEF_TSIZE_RST = 16'd16;

  // Depths of the command queue and the result queue (powers of two).
  localparam int CMD_QDEPTH = 4;
  localparam int OUT_QDEPTH = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TSIZE = 1'b1;

  // Command codes passed from the front end to the back end.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic signed [15:0] query_x;
    logic signed [15:0] query_y;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic        load_ok;
    logic [15:0] tile_value;
    logic        is_solid;
    logic [7:0]  map_width;
    logic [7:0]  map_height;
    logic [15:0] tile_size;
    logic [15:0] type_count;
    logic        map_loaded;
  } out_t;

  typedef struct packed {
    logic [1:0]         op;
    logic               ok;
    logic               wr;
    logic [15:0]        wdata;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic [15:0]        st_w;
    logic [15:0]        st_h;
    logic [15:0]        st_ts;
    logic [15:0]        st_cnt;
  } cmd_t;

endpackage

`default_nettype wire

>>> src/tmil_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tmil_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/tmil_fifo.sv
// Small register-based queue that separates the front end from the back end.
`default_nettype none

module tmil_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_r + PTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

`default_nettype wire

>>> src/tmil_front.sv
// Front end: parses the image byte stream and turns items into commands.
`default_nettype none

module tmil_front import tmil_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire in_t         item,
  input  wire logic [31:0] magic,
  input  wire logic [15:0] dflt_tsize,
  output logic             cmd_push,
  output cmd_t             cmd
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int AREA_W = 2 * SIDE_W;
  // Wide enough that the saturated count always lies beyond a full image.
  localparam int POS_W  = $clog2(2 * MAX_SIDE * MAX_SIDE + 32) + 1;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  logic [POS_W-1:0]  pos_r, pos_inc, kpos;
  logic [31:0]       hdr_r, hdr_base;
  logic [15:0]       sw_r, sh_r, sts_r, scnt_r;
  logic [7:0]        low_r;
  logic [AREA_W-1:0] area_r;
  logic              is_byte, pos_zero, in_cells, sides_ok, write_cell;
  logic              enough, load_ok;
  logic [POS_W-2:0]  cell_idx;

  assign is_byte  = take && !item.kind;
  assign pos_zero = (pos_r == '0);
  assign pos_inc  = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
  assign hdr_base = pos_zero ? 32'd0 : hdr_r;

  assign sides_ok = (sw_r != '0) && (sh_r != '0) &&
                    (sw_r <= 16'(MAX_SIDE)) && (sh_r <= 16'(MAX_SIDE));

  assign in_cells   = (pos_r >= POS_W'(HDR_BYTES));
  assign kpos       = pos_r - POS_W'(HDR_BYTES);
  assign cell_idx   = kpos[POS_W-1:1];
  assign write_cell = in_cells && kpos[0] && sides_ok &&
                      (cell_idx < (POS_W-1)'(area_r));

  // The count after this byte must cover the header and every cell.
  assign enough  = (pos_inc >= POS_W'(HDR_BYTES)) &&
                   ((pos_inc - POS_W'(HDR_BYTES)) >= POS_W'({area_r, 1'b0}));
  assign load_ok = enough && (hdr_r == magic) && sides_ok;

  assign cmd_push = take && (item.kind || item.last_byte || pos_zero || write_cell);

  always_comb begin
    cmd        = '0;
    cmd.ok     = load_ok;
    cmd.wr     = write_cell;
    cmd.wdata  = {item.data_byte, low_r};
    cmd.qx     = item.query_x;
    cmd.qy     = item.query_y;
    cmd.st_w   = sw_r;
    cmd.st_h   = sh_r;
    cmd.st_ts  = (sts_r == '0) ? dflt_tsize : sts_r;
    cmd.st_cnt = scnt_r;
    if (item.kind) begin
      cmd.op = OP_LOOKUP;
    end else if (item.last_byte) begin
      cmd.op = OP_STATUS;
    end else if (pos_zero) begin
      cmd.op = OP_CLEAR;
    end else begin
      cmd.op = OP_WRITE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (is_byte) begin
      pos_r <= item.last_byte ? '0 : pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= '0;
      sw_r   <= '0;
      sh_r   <= '0;
      sts_r  <= '0;
      scnt_r <= '0;
      low_r  <= '0;
    end else if (is_byte) begin
      if (pos_zero) begin
        sw_r   <= '0;
        sh_r   <= '0;
        sts_r  <= '0;
        scnt_r <= '0;
        low_r  <= '0;
      end
      if (pos_r < POS_W'(HDR_MAGIC_END)) begin
        hdr_r <= {item.data_byte, hdr_base[31:8]};
      end else if (pos_r < POS_W'(HDR_FIELDS_END)) begin
        if (!pos_r[0]) begin
          low_r <= item.data_byte;
        end else begin
          unique case (pos_r[3:1])
            3'd2:    sw_r   <= {item.data_byte, low_r};
            3'd3:    sh_r   <= {item.data_byte, low_r};
            3'd4:    sts_r  <= {item.data_byte, low_r};
            3'd5:    scnt_r <= {item.data_byte, low_r};
            default: low_r  <= low_r;
          endcase
        end
      end else if (in_cells && !kpos[0]) begin
        low_r <= item.data_byte;
      end
    end
  end

  // Cell count of the staged header; settles long before the first cell.
  always_ff @(posedge clk) begin
    area_r <= AREA_W'(sw_r[SIDE_W-1:0]) * AREA_W'(sh_r[SIDE_W-1:0]);
  end

endmodule

`default_nettype wire

>>> src/tmil_back.sv
// Back end: holds the map, executes commands and queues the results.
`default_nettype none

module tmil_back import tmil_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  input  wire logic [15:0] dflt_tsize,
  input  wire logic        out_pop,
  output logic             out_empty,
  output out_t             out_data
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int AREA_W = 2 * SIDE_W;
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OPTR_W = $clog2(OUT_QDEPTH);
  localparam int OCNT_W = $clog2(OUT_QDEPTH + 1);

  logic [SIDE_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [15:0]       tsize_r, tsize_nxt, count_r, count_nxt;
  logic              loaded_r, loaded_nxt;
  logic [ADDR_W-1:0] wptr_r, wptr_nxt;

  logic              take, credit, in_map, ram_we, ram_re;
  logic [ADDR_W-1:0] raddr;
  logic [AREA_W-1:0] lin;
  logic [15:0]       ram_rdata;

  logic              b_valid_r, b_useram_r;
  out_t              b_res_r, b_res_nxt, oq_in;
  logic [15:0]       oq_val;

  out_t              oq_mem_r [OUT_QDEPTH];
  logic [OPTR_W-1:0] oq_wp_r, oq_rp_r;
  logic [OCNT_W-1:0] oq_cnt_r;
  logic              oq_push, oq_pop;

  // Room for the result in flight as well as the one about to be made.
  assign credit  = ({1'b0, oq_cnt_r} + (OCNT_W+1)'(b_valid_r)) < (OCNT_W+1)'(OUT_QDEPTH);
  assign take    = cmd_valid && credit;
  assign cmd_pop = take;

  assign in_map = !cmd.qx[15] && !cmd.qy[15] &&
                  (cmd.qx[14:0] < 15'(width_r)) && (cmd.qy[14:0] < 15'(height_r));
  assign lin    = AREA_W'(cmd.qy[SIDE_W-1:0]) * AREA_W'(width_r) +
                  AREA_W'(cmd.qx[SIDE_W-1:0]);
  assign raddr  = ADDR_W'(lin);
  assign ram_re = take && (cmd.op == OP_LOOKUP);
  assign ram_we = take && ((cmd.op == OP_WRITE) || ((cmd.op == OP_STATUS) && cmd.wr));

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    tsize_nxt  = tsize_r;
    count_nxt  = count_r;
    loaded_nxt = loaded_r;
    wptr_nxt   = ram_we ? wptr_r + ADDR_W'(1) : wptr_r;
    if (take) begin
      unique case (cmd.op)
        OP_CLEAR: begin
          width_nxt  = SIDE_W'(MAX_SIDE);
          height_nxt = SIDE_W'(MAX_SIDE);
          tsize_nxt  = dflt_tsize;
          count_nxt  = '0;
          loaded_nxt = 1'b0;
          wptr_nxt   = '0;
        end
        OP_STATUS: begin
          wptr_nxt = '0;
          if (cmd.ok) begin
            width_nxt  = cmd.st_w[SIDE_W-1:0];
            height_nxt = cmd.st_h[SIDE_W-1:0];
            tsize_nxt  = cmd.st_ts;
            count_nxt  = cmd.st_cnt;
            loaded_nxt = 1'b1;
          end else begin
            width_nxt  = SIDE_W'(MAX_SIDE);
            height_nxt = SIDE_W'(MAX_SIDE);
            tsize_nxt  = dflt_tsize;
            count_nxt  = '0;
            loaded_nxt = 1'b0;
          end
        end
        OP_WRITE, OP_LOOKUP: begin
          width_nxt = width_r;
        end
        default: begin
          width_nxt = width_r;
        end
      endcase
    end
  end

  // A status result shows the map as the load leaves it; a lookup shows it as it is.
  always_comb begin
    b_res_nxt             = '0;
    b_res_nxt.result_kind = (cmd.op == OP_LOOKUP);
    b_res_nxt.load_ok     = (cmd.op == OP_STATUS) && cmd.ok;
    b_res_nxt.tile_value  = ((cmd.op == OP_LOOKUP) && !in_map) ? 16'd1 : 16'd0;
    b_res_nxt.map_width   = 8'(width_nxt);
    b_res_nxt.map_height  = 8'(height_nxt);
    b_res_nxt.tile_size   = tsize_nxt;
    b_res_nxt.type_count  = count_nxt;
    b_res_nxt.map_loaded  = loaded_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= SIDE_W'(MAX_SIDE);
      height_r  <= SIDE_W'(MAX_SIDE);
      tsize_r   <= DEF_TSIZE_RST;
      count_r   <= '0;
      loaded_r  <= 1'b0;
      wptr_r    <= '0;
      b_valid_r <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      tsize_r   <= tsize_nxt;
      count_r   <= count_nxt;
      loaded_r  <= loaded_nxt;
      wptr_r    <= wptr_nxt;
      b_valid_r <= take && ((cmd.op == OP_LOOKUP) || (cmd.op == OP_STATUS));
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_res_r    <= b_res_nxt;
      b_useram_r <= (cmd.op == OP_LOOKUP) && in_map && loaded_r;
    end
  end

  tmil_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (cmd.wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Result queue.
  assign oq_val = b_useram_r ? ram_rdata : b_res_r.tile_value;
  always_comb begin
    oq_in            = b_res_r;
    oq_in.tile_value = oq_val;
    oq_in.is_solid   = (oq_val == 16'd1);
  end

  assign oq_push   = b_valid_r;
  assign out_empty = (oq_cnt_r == '0);
  assign oq_pop    = out_pop && !out_empty;
  assign out_data  = oq_mem_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wp_r <= oq_wp_r + OPTR_W'(1);
      end
      if (oq_pop) begin
        oq_rp_r <= oq_rp_r + OPTR_W'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + OCNT_W'(1);
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - OCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem_r[oq_wp_r] <= oq_in;
    end
  end

  // A result in flight always comes from a command taken the cycle before.
  a_result_from_take: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> $past(take))
    else $error("result stage loaded without a command");

  // The credit check must keep the result queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> ((oq_cnt_r < OCNT_W'(OUT_QDEPTH)) || oq_pop))
    else $error("result queue overflow");

  // Cell memory is only consulted for a lookup on a loaded map.
  a_ram_only_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_useram_r) |-> (b_res_r.result_kind && b_res_r.map_loaded))
    else $error("cell memory read for an unloaded map");

endmodule

`default_nettype wire

>>> src/tile_map_image_loader.sv
// Top level of the tile-map image loader: configuration registers and the two halves.
`default_nettype none

// Usage
// The input channel behaves as a queue: an item is taken on a clock edge with in_push
// high and in_full low. An item is either one byte of a map image or a cell lookup.
// The byte flagged last_byte ends the image and produces one status transaction; each
// lookup produces one answer transaction. Other image bytes produce nothing.
// Results come out of a queue: the oldest waiting transaction sits on out_data while
// out_empty is low and is removed on an edge with out_pop high.
// Configuration (magic word, default tile size) is written through cfg_valid/cfg_ready,
// which is always ready; writes are meant to happen while the block is idle.
// Path of a result: the command queue, then the back end's result stage together with
// the synchronous cell memory read, then the result queue that drives out_data.
// Throughput: one item per cycle while in_full is low, set by the single read port of the
// cell memory and the one-per-cycle command rate of the back end.
// Reset leaves an empty map of MAX_SIDE by MAX_SIDE cells that reads as zero; no
// clearing pass runs, as cell memory is only read once a load has passed.
// When the receiver stalls, results collect in a four-entry queue, then the command
// queue fills and in_full rises; nothing is dropped.

module tile_map_image_loader import tmil_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire in_t                  in_data,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  logic [31:0] magic_r;
  logic [15:0] dts_r;
  logic        take, cmd_push, cmdq_empty, cmd_pop;
  cmd_t        cmd_in, cmd_out;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0;
      dts_r   <= DEF_TSIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAGIC: magic_r <= cfg_data;
        CFG_TSIZE: dts_r   <= cfg_data[15:0];
        default:   magic_r <= magic_r;
      endcase
    end
  end

  assign take = in_push && !in_full;

  // The front end follows the byte stream and classifies each item.
  tmil_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .item       (in_data),
    .magic      (magic_r),
    .dflt_tsize (dts_r),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  // The command queue lets the front end keep taking items while the back end waits.
  tmil_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_QDEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmdq_empty)
  );

  // The back end owns the map state and cell memory and produces every result.
  tmil_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (!cmdq_empty),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .dflt_tsize (dts_r),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

>>> verif/tile_map_checker.sv
// Checker for the tile-map image loader: predicts every result transaction and compares it.
module tile_map_checker import tmil_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  in_t                  in_data,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  out_t                 out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_count,
  output int                   answers_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   CELLS       = MAX_SIDE * MAX_SIDE;
  localparam int   PRINT_LIMIT = 40;
  localparam logic ITEM_LOOKUP = 1'b1;
  localparam logic RES_STATUS  = 1'b0;
  localparam logic RES_LOOKUP  = 1'b1;

  // Registers as the block should hold them.
  logic [31:0] magic_word;
  logic [15:0] fallback_tsize;

  // Visible map state.
  logic [15:0] cell_mem [CELLS];
  int unsigned side_w, side_h;
  logic [15:0] tsize_now, types_now;
  bit          map_ready;

  // Header parsing state of the load in progress.
  int unsigned byte_idx;
  logic [31:0] magic_shift;
  logic [15:0] hdr_w, hdr_h, hdr_ts, hdr_cnt;
  logic [7:0]  low_half;

  out_t awaited[$];
  out_t status_item;
  int   misses = 0;

  function automatic bit header_sides_ok();
    return hdr_w != 0 && hdr_h != 0 && hdr_w <= MAX_SIDE && hdr_h <= MAX_SIDE;
  endfunction

  function automatic void clear_map();
    side_w    = MAX_SIDE;
    side_h    = MAX_SIDE;
    tsize_now = fallback_tsize;
    types_now = '0;
    map_ready = 1'b0;
  endfunction

  function automatic out_t map_state();
    out_t r;
    r            = '0;
    r.map_width  = 8'(side_w);
    r.map_height = 8'(side_h);
    r.tile_size  = tsize_now;
    r.type_count = types_now;
    r.map_loaded = map_ready;
    return r;
  endfunction

  // Consumes one image byte; returns 1 with the status when the byte ends the load.
  function automatic bit take_image_byte(logic [7:0] b, logic last, output out_t r);
    int unsigned k, area;
    bit          ok;
    r = '0;
    if (byte_idx == 0) begin
      clear_map();
      magic_shift = '0;
      hdr_w       = '0;
      hdr_h       = '0;
      hdr_ts      = '0;
      hdr_cnt     = '0;
      low_half    = '0;
    end
    area = hdr_w * hdr_h;
    if (byte_idx < HDR_MAGIC_END) begin
      magic_shift = {b, magic_shift[31:8]};
    end else if (byte_idx < HDR_FIELDS_END) begin
      if (byte_idx % 2 == 0) begin
        low_half = b;
      end else begin
        case ((byte_idx - HDR_MAGIC_END) / 2)
          0:       hdr_w   = {b, low_half};
          1:       hdr_h   = {b, low_half};
          2:       hdr_ts  = {b, low_half};
          default: hdr_cnt = {b, low_half};
        endcase
      end
    end else if (byte_idx >= HDR_BYTES) begin
      k = byte_idx - HDR_BYTES;
      if (k % 2 == 0) begin
        low_half = b;
      end else if (header_sides_ok() && k / 2 < area && k / 2 < CELLS) begin
        cell_mem[k / 2] = {b, low_half};
      end
    end
    if (byte_idx != 32'hFFFF_FFFF) byte_idx++;
    if (!last) return 1'b0;

    ok = byte_idx >= HDR_BYTES && magic_shift == magic_word && header_sides_ok();
    if (ok && byte_idx < HDR_BYTES + 2 * area) ok = 1'b0;
    if (ok) begin
      side_w    = hdr_w;
      side_h    = hdr_h;
      tsize_now = (hdr_ts == 0) ? fallback_tsize : hdr_ts;
      types_now = hdr_cnt;
      map_ready = 1'b1;
    end else begin
      clear_map();
    end
    byte_idx      = 0;
    r             = map_state();
    r.result_kind = RES_STATUS;
    r.load_ok     = ok;
    return 1'b1;
  endfunction

  function automatic out_t answer_lookup(logic signed [15:0] qx, logic signed [15:0] qy);
    int          x, y;
    int unsigned idx;
    logic [15:0] v;
    out_t        r;
    x = qx;
    y = qy;
    if (x < 0 || y < 0 || x >= int'(side_w) || y >= int'(side_h)) begin
      v = 16'd1;
    end else if (!map_ready) begin
      v = 16'd0;
    end else begin
      idx = y * side_w + x;
      v   = (idx < CELLS) ? cell_mem[idx] : 16'd0;
    end
    r             = map_state();
    r.result_kind = RES_LOOKUP;
    r.tile_value  = v;
    r.is_solid    = (v == 16'd1);
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [$bits(out_t)-1:0] got,
                               logic [$bits(out_t)-1:0] want);
    misses++;
    if (misses <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic compare_result(out_t got);
    out_t want;
    if (awaited.size() == 0) begin
      note_mismatch("result with nothing awaited", got, '0);
    end else begin
      want = awaited.pop_front();
      if (got.result_kind != want.result_kind)
        note_mismatch("result_kind", got.result_kind, want.result_kind);
      if (got.load_ok != want.load_ok)
        note_mismatch("load_ok", got.load_ok, want.load_ok);
      if (got.tile_value != want.tile_value)
        note_mismatch("tile_value", got.tile_value, want.tile_value);
      if (got.is_solid != want.is_solid)
        note_mismatch("is_solid", got.is_solid, want.is_solid);
      if (got.map_width != want.map_width)
        note_mismatch("map_width", got.map_width, want.map_width);
      if (got.map_height != want.map_height)
        note_mismatch("map_height", got.map_height, want.map_height);
      if (got.tile_size != want.tile_size)
        note_mismatch("tile_size", got.tile_size, want.tile_size);
      if (got.type_count != want.type_count)
        note_mismatch("type_count", got.type_count, want.type_count);
      if (got.map_loaded != want.map_loaded)
        note_mismatch("map_loaded", got.map_loaded, want.map_loaded);
    end
  endtask

  // Results are compared before the new item is predicted, so that a result can never be
  // matched against an expectation raised at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      magic_word     = '0;
      fallback_tsize = DEF_TSIZE_RST;
      clear_map();
      byte_idx       = 0;
      magic_shift    = '0;
      hdr_w          = '0;
      hdr_h          = '0;
      hdr_ts         = '0;
      hdr_cnt        = '0;
      low_half       = '0;
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAGIC: magic_word     = cfg_data;
          CFG_TSIZE: fallback_tsize = cfg_data[15:0];
          default:   ;
        endcase
      end
      if (out_pop && !out_empty) compare_result(out_data);
      if (in_push && !in_full) begin
        if (in_data.kind == ITEM_LOOKUP)
          awaited.push_back(answer_lookup(in_data.query_x, in_data.query_y));
        else if (take_image_byte(in_data.data_byte, in_data.last_byte, status_item))
          awaited.push_back(status_item);
      end
    end
    fail_count  <= misses;
    answers_due <= awaited.size();
  end

endmodule

>>> verif/tile_map_image_loader_test.sv
// Testbench top of the tile-map image loader: stimulus, flow control and the verdict.
module tile_map_image_loader_test import tmil_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // The run is far shorter than this; the limit only catches a block that hangs.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Roughly how many input transactions each random phase offers.
  localparam int PHASE_ITEMS = 65;
  // Length of the long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 300;
  // Cycles allowed for an item in flight to leave the block, with margin.
  localparam int FLUSH_CYCLES = 4;

  localparam logic ITEM_IMAGE  = 1'b0;
  localparam logic ITEM_LOOKUP = 1'b1;

  // Shapes of image that the stimulus can produce. The first few loads of the run walk
  // through all of them once; after that they are drawn at random, mostly well formed.
  typedef enum int {
    LD_GOOD         = 0,
    LD_EXTRA        = 1,
    LD_ZERO_TS      = 2,
    LD_BAD_MAGIC    = 3,
    LD_ZERO_SIDE    = 4,
    LD_BIG_SIDE     = 5,
    LD_SHORT_HEADER = 6,
    LD_SHORT_CELLS  = 7
  } load_kind_t;
  localparam int LOAD_KINDS = 8;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_push   = 1'b0;
  logic                 in_full;
  in_t                  in_data   = '0;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MAGIC;
  logic [31:0]          cfg_data  = '0;

  int fail_count;
  int answers_due;

  int          cycle_count   = 0;
  int          items_sent    = 0;
  int          loads_done    = 0;
  logic [31:0] magic_now     = '0;
  bit          steady        = 1'b0;
  int          hold_requests = 0;
  int          holds_served  = 0;
  int          hold_left     = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tile_map_image_loader dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tile_map_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .answers_due (answers_due)
  );

  // Watchdog: a run that never drains ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver. Normally it declines a transaction in about one cycle in seven; in steady
  // stretches it always takes. When the stimulus asks for a hold-off, pop stays low while
  // hold_left, loaded from HOLD_CYCLES, counts down and the sender keeps offering items,
  // so that the result queue and then the command queue fill and in_full rises.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_pop   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_pop      <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_pop <= rst_n && (steady || $urandom_range(0, 99) >= 15);
    end
  end

  // Offers one item and returns at the edge that accepts it. Push is left high so that
  // back-to-back items flow without a bubble; now and again a short gap is inserted.
  task automatic push_item(in_t item);
    in_data <= item;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    items_sent++;
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Unused fields carry random values too, as the block must ignore them.
  task automatic send_byte(logic [7:0] b, logic last);
    in_t it;
    it.kind      = ITEM_IMAGE;
    it.data_byte = b;
    it.last_byte = last;
    it.query_x   = 16'($urandom);
    it.query_y   = 16'($urandom);
    push_item(it);
  endtask

  task automatic ask_cell(logic signed [15:0] x, logic signed [15:0] y);
    in_t it;
    it.kind      = ITEM_LOOKUP;
    it.data_byte = 8'($urandom);
    it.last_byte = 1'($urandom);
    it.query_x   = x;
    it.query_y   = y;
    push_item(it);
  endtask

  // Mostly near the map (inside and just past the far edge), sometimes the extremes of
  // the signed range or anything at all.
  function automatic logic signed [15:0] pick_coord(int span);
    case ($urandom_range(0, 19))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'($urandom);
      3:       return -16'sd1;
      default: return 16'($urandom_range(0, span + 1));
    endcase
  endfunction

  // Cell contents favour the barrier value and zero, so the solid flag toggles often.
  function automatic logic [15:0] pick_cell();
    case ($urandom_range(0, 9))
      0:       return 16'd1;
      1:       return 16'd0;
      2:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic put_word16(ref logic [7:0] img[$], input logic [15:0] v);
    img.push_back(v[7:0]);
    img.push_back(v[15:8]);
  endtask

  // Little-endian header: magic, width, height, tile size, tile count, reserved flags.
  task automatic put_header(ref logic [7:0] img[$], input logic [31:0] mg,
                            input logic [15:0] w, h, ts, cnt);
    for (int i = 0; i < HDR_MAGIC_END; i++) img.push_back(mg[8*i +: 8]);
    put_word16(img, w);
    put_word16(img, h);
    put_word16(img, ts);
    put_word16(img, cnt);
    repeat (HDR_BYTES - HDR_FIELDS_END) img.push_back(8'($urandom));
  endtask

  // Streams the first len bytes of an image, flagging the last one, with lookups mixed
  // in at the given percentage; those before the last byte see the map cleared by the load in progress.
  task automatic send_image(ref logic [7:0] img[$], input int len, input int span,
                            input int lookup_pct);
    for (int i = 0; i < len; i++) begin
      send_byte(img[i], i == len - 1);
      if ($urandom_range(0, 99) < lookup_pct) ask_cell(pick_coord(span), pick_coord(span));
    end
  endtask

  function automatic load_kind_t choose_load(int n);
    if (n < LOAD_KINDS) return load_kind_t'(n);
    case ($urandom_range(0, 15))
      8:       return LD_EXTRA;
      9:       return LD_ZERO_TS;
      10:      return LD_BAD_MAGIC;
      11:      return LD_ZERO_SIDE;
      12:      return LD_BIG_SIDE;
      13:      return LD_SHORT_HEADER;
      14:      return LD_SHORT_CELLS;
      default: return LD_GOOD;
    endcase
  endfunction

  // One complete load ending in a flagged last byte, followed by a few lookups. Sides of
  // zero mean small random sides; the large maps are asked for explicitly.
  task automatic run_load(load_kind_t kind, int force_w, int force_h);
    logic [7:0]  img[$];
    logic [31:0] mg;
    logic [15:0] w, h, ts, oversize;
    int          len, ncells, span, pct;
    w  = (force_w != 0) ? 16'(force_w) : 16'($urandom_range(1, 4));
    h  = (force_h != 0) ? 16'(force_h) : 16'($urandom_range(1, 5));
    ts = (kind == LD_ZERO_TS || $urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
    mg = magic_now;
    case ($urandom_range(0, 3))
      0:       oversize = 16'(MAX_SIDE_DEF + 1);
      1:       oversize = 16'd256;
      2:       oversize = 16'hFFFF;
      default: oversize = 16'($urandom_range(MAX_SIDE_DEF + 1, 16'hFFFF));
    endcase
    case (kind)
      LD_BAD_MAGIC: mg = mg ^ (32'h1 << $urandom_range(0, 31));
      LD_ZERO_SIDE: begin
        if ($urandom_range(0, 1) == 0) w = '0;
        else h = '0;
      end
      LD_BIG_SIDE: begin
        case ($urandom_range(0, 2))
          0:       w = oversize;
          1:       h = oversize;
          default: begin
            w = oversize;
            h = oversize;
          end
        endcase
      end
      default: ;
    endcase

    put_header(img, mg, w, h, ts, 16'($urandom));
    // A header with bad sides still gets up to four trailing cell words.
    if (w != 0 && h != 0 && w <= MAX_SIDE_DEF && h <= MAX_SIDE_DEF) ncells = w * h;
    else ncells = $urandom_range(0, 4);
    repeat (ncells) put_word16(img, pick_cell());
    if (kind == LD_EXTRA) repeat ($urandom_range(1, 6)) img.push_back(8'($urandom));

    case (kind)
      LD_SHORT_HEADER: len = $urandom_range(1, HDR_BYTES - 1);
      LD_SHORT_CELLS:  len = $urandom_range(HDR_BYTES, img.size() - 1);
      default:         len = img.size();
    endcase

    span = (force_w != 0) ? MAX_SIDE_DEF : 5;
    pct  = (force_w != 0) ? 2 : 6;
    send_image(img, len, span, pct);
    repeat ($urandom_range(1, 4)) ask_cell(pick_coord(span), pick_coord(span));
    loads_done++;
  endtask

  task automatic random_phase(int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) run_load(choose_load(loads_done), 0, 0);
  endtask

  // The sender stops until every awaited result has been taken, then lets the pipeline
  // empty of items that produce no result. Configuration is only written after this.
  task automatic settle();
    in_push <= 1'b0;
    do @(posedge clk); while (answers_due != 0);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  // Writes both registers in back-to-back transactions; valid stays high between them.
  task automatic configure(logic [31:0] mg, logic [15:0] ts);
    cfg_index <= CFG_MAGIC;
    cfg_data  <= mg;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_TSIZE;
    cfg_data  <= 32'(ts);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    magic_now = mg;
  endtask

  initial begin
    logic [7:0] img[$];

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the reset register values (magic zero, tile size sixteen).
    // Before any load, cells inside the full-size empty map read zero, anything outside
    // reads as a barrier.
    ask_cell(16'sd0, 16'sd0);
    ask_cell(16'(MAX_SIDE_DEF - 1), 16'(MAX_SIDE_DEF - 1));
    ask_cell(16'(MAX_SIDE_DEF), 16'sd0);
    ask_cell(16'sh8000, 16'sh7FFF);
    ask_cell(16'sh7FFF, -16'sd1);
    // A load of a single byte is far too short and must fail.
    send_byte(8'hFF, 1'b1);
    // Smallest valid map: one barrier cell, zero tile size so the default applies, and
    // the largest tile count.
    put_header(img, 32'h0, 16'd1, 16'd1, 16'd0, 16'hFFFF);
    put_word16(img, 16'd1);
    send_image(img, img.size(), 1, 0);
    ask_cell(16'sd0, 16'sd0);
    ask_cell(16'sd1, 16'sd0);
    settle();

    // Random phases, each under a different register setting.
    configure($urandom, 16'd1);
    random_phase(PHASE_ITEMS);
    settle();

    // Largest register values. The receiver holds off for a long stretch while a burst
    // of lookups is offered, so the block backs up and stalls its input.
    configure(32'hFFFF_FFFF, 16'hFFFF);
    hold_requests <= hold_requests + 1;
    repeat (24) ask_cell(pick_coord(5), pick_coord(5));
    random_phase(PHASE_ITEMS);
    settle();

    // A zero default tile size is taken as written.
    configure(32'h0, 16'h0);
    random_phase(PHASE_ITEMS);
    settle();

    configure($urandom, 16'($urandom_range(1, 16'hFFFF)));
    random_phase(PHASE_ITEMS);
    settle();

    // A full-width single row, which also runs as the long stretch without idling on
    // either side, then lookups along it and just past its edges.
    configure($urandom, DEF_TSIZE_RST);
    steady <= 1'b1;
    run_load(LD_GOOD, MAX_SIDE_DEF, 1);
    steady <= 1'b0;
    ask_cell(16'sd0, 16'sd0);
    ask_cell(16'(MAX_SIDE_DEF - 1), 16'sd0);
    ask_cell(16'(MAX_SIDE_DEF), 16'sd0);
    ask_cell(16'(MAX_SIDE_DEF - 1), 16'sd1);
    repeat (20) ask_cell(pick_coord(MAX_SIDE_DEF), pick_coord(1));

    // Drain, then leave room for any stray transaction before the verdict.
    settle();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
